// File: rtl/u2a_pkg.sv
package u2a_pkg;

  localparam int MAX_CHARS  = 10;
  localparam int CNT_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int IN_BITS    = 32;
  localparam int CHAR_W     = 7;
  localparam int DEC_SHIFT  = 35;

  localparam logic [31:0]        DEC_RECIP = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
  localparam logic [DIGIT_W-1:0] DEC_TEN   = 4'd10;

  localparam logic KIND_DEC = 1'b0;
  localparam logic KIND_HEX = 1'b1;

  typedef struct packed {
    logic [IN_BITS-1:0] value;
    logic               kind;
    logic               port_select;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              port_out;
    logic              last;
  } out_t;

  // digits held least significant first
  typedef struct packed {
    logic [MAX_CHARS-1:0][DIGIT_W-1:0] digits;
    logic [CNT_W-1:0]                  count;
    logic                              port;
  } entry_t;

  function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_TEN);
    end
    return c;
  endfunction

endpackage

// File: rtl/u2a_front.sv
module u2a_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  u2a_pkg::in_t     in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output u2a_pkg::entry_t  push_data
);

  localparam int VW = (VALUE_BITS < u2a_pkg::IN_BITS) ? VALUE_BITS : u2a_pkg::IN_BITS;

  logic                                                busy;
  logic [VW-1:0]                                       v;
  logic                                                kind;
  logic                                                port;
  logic [u2a_pkg::CNT_W-1:0]                           cnt;
  logic [u2a_pkg::MAX_CHARS-1:0][u2a_pkg::DIGIT_W-1:0] digits;

  logic [VW+31:0]                  prod;
  logic [VW-1:0]                   q;
  logic [u2a_pkg::DIGIT_W-1:0]     q_ten;
  logic [u2a_pkg::DIGIT_W-1:0]     d;
  logic                            step_last;
  logic                            advance;
  logic                            accept;

  assign prod = {32'b0, v} * {{VW{1'b0}}, u2a_pkg::DEC_RECIP};

  // low nibble of q*10, enough to recover the remainder
  assign q_ten = {q[0], 3'b000} + {q[2:0], 1'b0};

  always_comb begin
    if (kind == u2a_pkg::KIND_HEX) begin
      q = v >> 4;
      d = v[3:0];
    end else begin
      q = VW'(prod >> u2a_pkg::DEC_SHIFT);
      d = v[3:0] - q_ten;
    end
  end

  assign step_last  = (q == '0) || (cnt == u2a_pkg::CNT_W'(u2a_pkg::MAX_CHARS - 1));
  assign push_valid = busy && step_last;
  assign advance    = busy && (!step_last || push_ready);
  assign in_ready   = !busy || (step_last && push_ready);
  assign accept     = in_valid && in_ready;

  always_comb begin
    push_data             = '0;
    push_data.digits      = digits;
    push_data.digits[cnt] = d;
    push_data.count       = cnt + 1'b1;
    push_data.port        = port;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (advance && step_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v    <= in_data.value[VW-1:0];
      kind <= in_data.kind;
      port <= in_data.port_select;
      cnt  <= '0;
    end else if (advance && !step_last) begin
      v           <= q;
      digits[cnt] <= d;
      cnt         <= cnt + 1'b1;
    end
  end

endmodule

// File: rtl/u2a_queue.sv
module u2a_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  u2a_pkg::entry_t  push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output u2a_pkg::entry_t  pop_data
);

  u2a_pkg::entry_t mem [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// File: rtl/u2a_back.sv
module u2a_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  u2a_pkg::entry_t  pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output u2a_pkg::out_t    out_data
);

  u2a_pkg::entry_t           cur;
  logic                      active;
  logic [u2a_pkg::CNT_W-1:0] idx;
  logic                      can_load;
  logic                      emit;
  logic                      done;
  logic                      do_pop;

  assign can_load  = !out_valid || out_ready;
  assign emit      = active && can_load;
  assign done      = emit && (idx == '0);
  assign pop_ready = !active || done;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_pop) begin
        active <= 1'b1;
      end else if (done) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      cur <= pop_data;
      idx <= pop_data.count - 1'b1;
    end else if (emit) begin
      idx <= idx - 1'b1;
    end
    if (emit) begin
      out_data.digit_char <= u2a_pkg::to_char(cur.digits[idx]);
      out_data.port_out   <= cur.port;
      out_data.last       <= (idx == '0);
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (idx < cur.count))
    else $error("character index beyond digit count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    do_pop |-> (pop_data.count != '0) &&
               (pop_data.count <= u2a_pkg::CNT_W'(u2a_pkg::MAX_CHARS)))
    else $error("queued entry with bad digit count");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.digit_char >= 7'h30) && (out_data.digit_char <= 7'h39)) ||
                  ((out_data.digit_char >= 7'h41) && (out_data.digit_char <= 7'h46)))
    else $error("output character outside digit set");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && idx == '0 && !do_pop) |=> !active)
    else $error("entry still active after its last character");

endmodule

// File: rtl/unsigned_to_ascii_digits.sv
// Unsigned binary to ASCII digits, decimal or upper-case hexadecimal.
// Input channel (in_valid/in_ready/in_data): value, kind (0 decimal, 1 hex),
// port_select. Output channel (out_valid/out_ready/out_data): one transfer per
// character, most significant first, port_out copied, last on the final one.
// Leading zeros are dropped; zero gives the single character '0'.
// The front converts one digit per cycle (a reciprocal multiply for decimal,
// a nibble shift for hex), holding the last digit while the two-entry queue is
// full; the back emits the digits in reverse order through an output register.
// The digit count is 1 to 10 for decimal and 1 to 8 for hex. The front takes a
// new input as it pushes the last digit of the previous one, and the pace with
// an always-ready receiver is set by the one-digit-per-cycle converter and the
// one-character-per-cycle output.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops once the converter has a finished item it cannot push.
// Reset (synchronous, active high) empties the converter, queue and output.
module unsigned_to_ascii_digits #(
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  u2a_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output u2a_pkg::out_t  out_data
);

  logic            push_valid;
  logic            push_ready;
  u2a_pkg::entry_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  u2a_pkg::entry_t pop_data;

  u2a_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  u2a_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  u2a_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: tb/tb_unsigned_to_ascii_digits.sv
`timescale 1ns / 1ps

class digit_scoreboard;
  localparam logic [u2a_pkg::CHAR_W-1:0] ASCII_ZERO    = 7'h30;
  localparam logic [u2a_pkg::CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
  localparam int unsigned                DEC_RADIX     = 10;
  localparam int unsigned                HEX_RADIX     = 16;

  u2a_pkg::out_t pending_chars[$];
  int unsigned   errors;

  function new();
    errors = 0;
  endfunction

  // digits of an accepted number, most significant first
  function void note_number(u2a_pkg::in_t n);
    logic [u2a_pkg::IN_BITS-1:0] v;
    int unsigned                 radix;
    logic [3:0]                  d;
    u2a_pkg::out_t               c;
    u2a_pkg::out_t               chars[$];
    v = n.value;
    radix = (n.kind == u2a_pkg::KIND_HEX) ? HEX_RADIX : DEC_RADIX;
    do begin
      d = 4'(v % radix);
      v = v / radix;
      if (d < DEC_RADIX) begin
        c.digit_char = ASCII_ZERO + u2a_pkg::CHAR_W'(d);
      end else begin
        c.digit_char = ASCII_UPPER_A + u2a_pkg::CHAR_W'(d - DEC_RADIX);
      end
      c.port_out = n.port_select;
      c.last = 1'b0;
      chars.push_front(c);
    end while (v != 0);
    chars[chars.size() - 1].last = 1'b1;
    foreach (chars[i]) pending_chars.push_back(chars[i]);
  endfunction

  function void check_char(u2a_pkg::out_t got);
    u2a_pkg::out_t exp;
    if (pending_chars.size() == 0) begin
      $display("%0t: unexpected char=%h port=%b last=%b", $time,
               got.digit_char, got.port_out, got.last);
      errors++;
      return;
    end
    exp = pending_chars.pop_front();
    if (got.digit_char !== exp.digit_char || got.port_out !== exp.port_out ||
        got.last !== exp.last) begin
      $display("%0t: mismatch expected char=%h port=%b last=%b, got char=%h port=%b last=%b",
               $time, exp.digit_char, exp.port_out, exp.last,
               got.digit_char, got.port_out, got.last);
      errors++;
    end
  endfunction
endclass

module tb_unsigned_to_ascii_digits;
  localparam int          RESET_CYCLES = 5;
  localparam int          IDLE_LIMIT   = 20000;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          PHASE_ITEMS  = 60;
  localparam logic [31:0] TEN          = 32'd10;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  u2a_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  u2a_pkg::out_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  digit_scoreboard sb = new();

  unsigned_to_ascii_digits dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_char(out_data);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic u2a_pkg::in_t make_number(logic [31:0] value, logic kind, logic port);
    u2a_pkg::in_t n;
    n.value = value;
    n.kind = kind;
    n.port_select = port;
    return n;
  endfunction

  function automatic u2a_pkg::in_t random_number();
    u2a_pkg::in_t n;
    logic [31:0]  p;
    p = 32'd1;
    case ($urandom_range(3))
      0: n.value = $urandom();
      1: n.value = $urandom() >> $urandom_range(31);
      2: n.value = $urandom_range(255);
      default: begin
        // around powers of ten, where the digit count changes
        repeat ($urandom_range(9)) p = p * TEN;
        n.value = p + 32'($urandom_range(2)) - 32'd1;
      end
    endcase
    n.kind = $urandom_range(1) ? u2a_pkg::KIND_HEX : u2a_pkg::KIND_DEC;
    n.port_select = 1'($urandom_range(1));
    return n;
  endfunction

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic send_number(u2a_pkg::in_t n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= n;
    do @(posedge clk); while (!in_ready);
    sb.note_number(n);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk);
  endtask

  u2a_pkg::in_t directed[$];

  initial begin
    directed = '{
      make_number(32'd0, u2a_pkg::KIND_DEC, 1'b0),
      make_number(32'd0, u2a_pkg::KIND_HEX, 1'b1),
      make_number(32'd1, u2a_pkg::KIND_DEC, 1'b0),
      make_number(32'd9, u2a_pkg::KIND_DEC, 1'b1),
      make_number(32'd10, u2a_pkg::KIND_DEC, 1'b0),
      make_number(32'd9, u2a_pkg::KIND_HEX, 1'b0),
      make_number(32'd10, u2a_pkg::KIND_HEX, 1'b1),
      make_number(32'd15, u2a_pkg::KIND_HEX, 1'b0),
      make_number(32'd16, u2a_pkg::KIND_HEX, 1'b1),
      make_number(32'd99, u2a_pkg::KIND_DEC, 1'b0),
      make_number(32'd100, u2a_pkg::KIND_DEC, 1'b1),
      make_number(32'd999999999, u2a_pkg::KIND_DEC, 1'b0),
      make_number(32'd1000000000, u2a_pkg::KIND_DEC, 1'b1),
      make_number(32'hFFFF_FFFF, u2a_pkg::KIND_DEC, 1'b1),
      make_number(32'hFFFF_FFFF, u2a_pkg::KIND_HEX, 1'b0),
      make_number(32'h8000_0000, u2a_pkg::KIND_HEX, 1'b1),
      make_number(32'h8000_0000, u2a_pkg::KIND_DEC, 1'b0),
      make_number(32'h5555_5555, u2a_pkg::KIND_HEX, 1'b1),
      make_number(32'hAAAA_AAAA, u2a_pkg::KIND_DEC, 1'b0),
      make_number(32'hABCD_EF01, u2a_pkg::KIND_HEX, 1'b1),
      make_number(32'h0FED_CBA9, u2a_pkg::KIND_HEX, 1'b0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      in_valid <= 1'b0;
      case (ph)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 80; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 80; end
        default: begin send_idle_pct <= 35; recv_stall_pct <= 35; end
      endcase
      @(posedge clk);
      repeat (PHASE_ITEMS) send_number(random_number());
    end

    // receiver holds off while the sender keeps offering, then sender pauses
    in_valid <= 1'b0;
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    hold_go <= ~hold_go;
    @(posedge clk);
    repeat (20) send_number(random_number());
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
